/* rtl/short_filename_formatter_defines.svh */
// assertion macros used by the short filename formatter core (sff_core)
`ifndef SHORT_FILENAME_FORMATTER_DEFINES_SVH
`define SHORT_FILENAME_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
`define SFF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SFF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFF_ASSERT(lbl, clk, rstn, prop, msg)
`define SFF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/sff_pkg.sv */
// types and constants for the short filename formatter
package sff_pkg;

  localparam int unsigned DefBaseChars  = 8;
  localparam int unsigned DefTotalChars = 11;
  localparam int unsigned PosW          = 4;
  localparam int unsigned CharW         = 8;

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharNul   = 8'h00;

  typedef enum logic [1:0] {
    PhBase = 2'd0,
    PhSkip = 2'd1,
    PhExt  = 2'd2,
    PhFull = 2'd3
  } phase_e;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_val;
    logic             last;
  } emit_t;

endpackage

/* rtl/short_filename_formatter.sv */
// Converts a zero-terminated filename, one byte per request, into the space-padded
// upper-case short name (BASE_CHARS base bytes, then the extension up to TOTAL_CHARS)
// followed by a zero byte marked with tlast. An ordinary character is taken in the same
// cycle that it is emitted or skipped, so a name streams in at one byte per clock while
// the output side keeps up. A dot that ends a short base, and the terminating zero, each
// hold the input while they emit their pad bytes, because the single output register
// moves one name byte per clock; a stalled output holds a byte that is to be emitted in
// the same cycle. A result passes from the input register through the output register.
module short_filename_formatter #(
  parameter int unsigned BASE_CHARS  = sff_pkg::DefBaseChars,
  parameter int unsigned TOTAL_CHARS = sff_pkg::DefTotalChars
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // is_last
);
  import sff_pkg::*;

  emit_t emit;
  logic  out_free;

  sff_core #(
    .BASE_CHARS (BASE_CHARS),
    .TOTAL_CHARS(TOTAL_CHARS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_char_i (s_axis_tdata),
    .out_free_i(out_free),
    .emit_o    (emit)
  );

  sff_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emit_i (emit),
    .free_o (out_free),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .char_o (m_axis_tdata),
    .last_o (m_axis_tlast)
  );

endmodule

/* rtl/sff_core.sv */
// input register and name formatting state machine
`include "short_filename_formatter_defines.svh"

module sff_core #(
  parameter int unsigned BASE_CHARS  = sff_pkg::DefBaseChars,
  parameter int unsigned TOTAL_CHARS = sff_pkg::DefTotalChars
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [sff_pkg::CharW-1:0]  in_char_i,
  input  logic                       out_free_i,
  output sff_pkg::emit_t             emit_o
);
  import sff_pkg::*;

  localparam int unsigned BaseLen = (BASE_CHARS > TOTAL_CHARS) ? TOTAL_CHARS : BASE_CHARS;
  localparam logic [PosW-1:0] BaseLim  = PosW'(BaseLen);
  localparam logic [PosW-1:0] TotalLim = PosW'(TOTAL_CHARS);

  function automatic logic [CharW-1:0] to_upper(input logic [CharW-1:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  logic             char_valid_q;
  logic [CharW-1:0] char_q;
  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  pos_inc;
  logic             consume;
  logic             want;
  logic [CharW-1:0] want_char;
  logic             want_last;
  phase_e           ext_phase;

  assign pos_inc   = pos_q + PosW'(1);
  assign ext_phase = (pos_q >= TotalLim) ? PhFull : PhExt;
  assign in_ready_o = !char_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_valid_q <= 1'b0;
      phase_q      <= PhBase;
      pos_q        <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      if (in_ready_o) begin
        char_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= in_char_i;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    consume   = 1'b0;
    want      = 1'b0;
    want_char = CharSpace;
    want_last = 1'b0;
    if (char_valid_q) begin
      if (char_q == CharNul) begin
        // pad to the full name, then close with a zero byte
        want = 1'b1;
        if (pos_q < TotalLim) begin
          if (out_free_i) begin
            pos_d = pos_inc;
          end
        end else begin
          want_char = CharNul;
          want_last = 1'b1;
          if (out_free_i) begin
            consume = 1'b1;
            pos_d   = '0;
            phase_d = PhBase;
          end
        end
      end else begin
        unique case (phase_q)
          PhBase: begin
            if (char_q == CharDot) begin
              if (pos_q < BaseLim) begin
                want = 1'b1;
                if (out_free_i) begin
                  pos_d = pos_inc;
                end
              end else begin
                consume = 1'b1;
                phase_d = ext_phase;
              end
            end else if (pos_q < BaseLim) begin
              want      = 1'b1;
              want_char = to_upper(char_q);
              if (out_free_i) begin
                consume = 1'b1;
                pos_d   = pos_inc;
                if (pos_inc >= BaseLim) begin
                  phase_d = PhSkip;
                end
              end
            end else begin
              consume = 1'b1;
              phase_d = PhSkip;
            end
          end
          PhSkip: begin
            consume = 1'b1;
            if (char_q == CharDot) begin
              phase_d = ext_phase;
            end
          end
          PhExt: begin
            if (pos_q < TotalLim) begin
              want      = 1'b1;
              want_char = to_upper(char_q);
              if (out_free_i) begin
                consume = 1'b1;
                pos_d   = pos_inc;
                if (pos_inc >= TotalLim) begin
                  phase_d = PhFull;
                end
              end
            end else begin
              consume = 1'b1;
              phase_d = PhFull;
            end
          end
          PhFull: begin
            consume = 1'b1;
          end
          default: begin
            consume = 1'b1;
          end
        endcase
      end
    end
  end

  assign emit_o.valid    = want && out_free_i;
  assign emit_o.char_val = want_char;
  assign emit_o.last     = want_last;

  `SFF_ASSERT(a_pos_bound, clk_i, rst_ni, pos_q <= TotalLim, "position past name length")
  `SFF_ASSERT(a_last_resets, clk_i, rst_ni,
    (emit_o.valid && emit_o.last) |=> (pos_q == '0 && phase_q == PhBase),
    "closing byte did not restart the name")
  `SFF_ASSERT(a_skip_pos, clk_i, rst_ni, (phase_q == PhSkip) |-> (pos_q >= BaseLim),
    "skip phase with base field not full")
  `SFF_ASSERT(a_full_pos, clk_i, rst_ni, (phase_q == PhFull) |-> (pos_q == TotalLim),
    "extension full with name not complete")

endmodule

/* rtl/sff_out_reg.sv */
// output register for formatted name bytes
module sff_out_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sff_pkg::emit_t            emit_i,
  output logic                      free_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [sff_pkg::CharW-1:0] char_o,
  output logic                      last_o
);
  import sff_pkg::*;

  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.valid) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      char_q <= emit_i.char_val;
      last_q <= emit_i.last;
    end
  end

endmodule
